@@ rtl/iolst_pkg.sv @@
// Package with the request codes, status codes and cell control type of the ordered list store.
package iolst_pkg;

    localparam int VALUE_W = 32;
    localparam int POS_W   = 4;
    localparam int COUNT_W = 5;

    typedef enum logic [1:0] {
        FUNC_APPEND = 2'd0,
        FUNC_INSERT = 2'd1,
        FUNC_DELETE = 2'd2,
        FUNC_READ   = 2'd3
    } t_func;

    typedef enum logic [1:0] {
        STATUS_DONE  = 2'd0,
        STATUS_RANGE = 2'd1,
        STATUS_FULL  = 2'd2
    } t_status;

    typedef struct packed {
        logic append;
        logic insert;
        logic delete;
    } t_cell_ctl;

endpackage

@@ rtl/iolst_cell.sv @@
// One element cell of the list chain, loading from the request or from a neighbor.
module iolst_cell #(
    parameter int CMP_W = 5,
    parameter int INDEX = 0
) (
    input  logic                            i_clk,
    input  iolst_pkg::t_cell_ctl            i_ctl,
    input  logic [CMP_W-1:0]                i_target,
    input  logic [iolst_pkg::VALUE_W-1:0]   i_value,
    input  logic [iolst_pkg::VALUE_W-1:0]   i_prev,
    input  logic [iolst_pkg::VALUE_W-1:0]   i_next,
    output logic [iolst_pkg::VALUE_W-1:0]   o_data,
    output logic [iolst_pkg::VALUE_W-1:0]   o_tap
);

    localparam logic [CMP_W-1:0] CELL_IDX = CMP_W'(INDEX);

    logic [iolst_pkg::VALUE_W-1:0] r_data;
    logic [iolst_pkg::VALUE_W-1:0] n_data;
    logic                          hit;
    logic                          above;

    assign hit   = (CELL_IDX == i_target);
    assign above = (CELL_IDX > i_target);

    always_comb begin
        n_data = r_data;
        if (i_ctl.append) begin
            if (hit) begin
                n_data = i_value;
            end
        end else if (i_ctl.insert) begin
            if (hit) begin
                n_data = i_value;
            end else if (above) begin
                n_data = i_prev;
            end
        end else if (i_ctl.delete) begin
            if (hit || above) begin
                n_data = i_next;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data = r_data;
    assign o_tap  = hit ? r_data : '0;

endmodule

@@ rtl/indexed_ordered_list_store.sv @@
// Top level of the ordered list store: request decode, cell chain and result register.
// A request accepted at a clock edge has its result registered and on the outputs in the
// following cycle, marked by o_valid. Throughput: one request per cycle; busy stays low
// because all cells that change load in parallel in the cycle of the request.
// Reset: a synchronous active-low reset empties the list and clears the result strobe.
// Element contents are not cleared; the receiver cannot stall the result.
module indexed_ordered_list_store #(
    parameter int DEPTH = 16
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic [1:0]                      i_func,
    input  logic signed [31:0]              i_value,
    input  logic [3:0]                      i_position,
    output logic                            o_valid,
    output logic [1:0]                      o_status,
    output logic signed [31:0]              o_read_value,
    output logic [4:0]                      o_count
);

    localparam int FILL_W = $clog2(DEPTH + 1);
    localparam int CMP_W  = (FILL_W > iolst_pkg::POS_W) ? FILL_W : iolst_pkg::POS_W;
    localparam int VW     = iolst_pkg::VALUE_W;
    localparam int CW     = iolst_pkg::COUNT_W;

    logic [FILL_W-1:0]       r_fill;
    logic [FILL_W-1:0]       n_fill;
    logic                    r_valid;
    iolst_pkg::t_status      r_status;
    iolst_pkg::t_status      n_status;
    logic [VW-1:0]           r_read_value;
    logic [VW-1:0]           n_read_value;
    logic [CW-1:0]           r_count;

    logic                    fire;
    logic [CMP_W-1:0]        fill_ext;
    logic [CMP_W-1:0]        pos_ext;
    logic                    full;
    logic                    out_of_range;
    iolst_pkg::t_cell_ctl    ctl;
    logic [CMP_W-1:0]        target;
    logic [VW-1:0]           read_bus;
    logic [CW+FILL_W-1:0]    count_wide;

    logic [VW-1:0]           cell_data [DEPTH];
    logic [VW-1:0]           cell_tap  [DEPTH];

    assign busy         = 1'b0;
    assign fire         = start && !busy;
    assign fill_ext     = CMP_W'(r_fill);
    assign pos_ext      = CMP_W'(i_position);
    assign full         = (fill_ext == CMP_W'(DEPTH));
    assign out_of_range = (pos_ext >= fill_ext);

    always_comb begin
        read_bus = '0;
        for (int k = 0; k < DEPTH; k++) begin
            read_bus = read_bus | cell_tap[k];
        end
    end

    always_comb begin
        ctl          = '0;
        n_fill       = r_fill;
        n_status     = iolst_pkg::STATUS_DONE;
        n_read_value = '0;
        target       = pos_ext;
        unique case (iolst_pkg::t_func'(i_func))
            iolst_pkg::FUNC_APPEND: begin
                target = fill_ext;
                if (full) begin
                    n_status = iolst_pkg::STATUS_FULL;
                end else begin
                    ctl.append = fire;
                    if (fire) begin
                        n_fill = r_fill + FILL_W'(1);
                    end
                end
            end
            iolst_pkg::FUNC_INSERT: begin
                if (pos_ext == '0 || out_of_range) begin
                    n_status = iolst_pkg::STATUS_RANGE;
                end else if (full) begin
                    n_status = iolst_pkg::STATUS_FULL;
                end else begin
                    ctl.insert = fire;
                    if (fire) begin
                        n_fill = r_fill + FILL_W'(1);
                    end
                end
            end
            iolst_pkg::FUNC_DELETE: begin
                if (out_of_range) begin
                    n_status = iolst_pkg::STATUS_RANGE;
                end else begin
                    ctl.delete = fire;
                    if (fire) begin
                        n_fill = r_fill - FILL_W'(1);
                    end
                end
            end
            iolst_pkg::FUNC_READ: begin
                if (out_of_range) begin
                    n_status = iolst_pkg::STATUS_RANGE;
                end else begin
                    n_read_value = read_bus;
                end
            end
        endcase
    end

    assign count_wide = {{CW{1'b0}}, n_fill};

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic [VW-1:0] prev_data;
        logic [VW-1:0] next_data;

        if (g == 0) begin : g_first
            assign prev_data = '0;
        end else begin : g_mid_prev
            assign prev_data = cell_data[g-1];
        end

        if (g == DEPTH - 1) begin : g_last
            assign next_data = cell_data[g];
        end else begin : g_mid_next
            assign next_data = cell_data[g+1];
        end

        iolst_cell #(
            .CMP_W (CMP_W),
            .INDEX (g)
        ) u_cell (
            .i_clk    (i_clk),
            .i_ctl    (ctl),
            .i_target (target),
            .i_value  (i_value),
            .i_prev   (prev_data),
            .i_next   (next_data),
            .o_data   (cell_data[g]),
            .o_tap    (cell_tap[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill  <= '0;
            r_valid <= 1'b0;
        end else begin
            r_fill  <= n_fill;
            r_valid <= fire;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_status     <= n_status;
            r_read_value <= n_read_value;
            r_count      <= count_wide[CW-1:0];
        end
    end

    assign o_valid      = r_valid;
    assign o_status     = r_status;
    assign o_read_value = r_read_value;
    assign o_count      = r_count;

    a_fill_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fill_ext <= CMP_W'(DEPTH))
        else $error("List length exceeds the depth.");

    a_request_answered: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire |=> o_valid)
        else $error("Accepted request gave no result.");

    a_fill_only_on_request: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_fill != $past(r_fill)) |-> $past(fire))
        else $error("Length changed without a request.");

    a_read_value_only_on_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_read_value != '0) |-> (o_status == iolst_pkg::STATUS_DONE))
        else $error("Nonzero read value on a failed request.");

endmodule

@@ verif/tb_indexed_ordered_list_store.sv @@
// Testbench of the ordered list store: directed and random requests checked by a scoreboard.
`timescale 1ns / 100ps

module tb_indexed_ordered_list_store;

    localparam int DEPTH           = 16;
    localparam int RANDOM_REQUESTS = 400;
    localparam int MAX_GAP         = 17;
    localparam int CYCLE_LIMIT     = 200000;
    localparam int REPORT_LIMIT    = 10;

    typedef struct {
        iolst_pkg::t_status status;
        logic signed [31:0] read_value;
        logic [4:0]         count;
    } t_outcome;

    class list_scoreboard;
        logic signed [31:0] cells [DEPTH];
        int unsigned        fill;
        t_outcome           outcomes [$];
        int unsigned        mismatches;

        function new();
            fill       = 0;
            mismatches = 0;
        endfunction

        function void note_request(iolst_pkg::t_func func, logic signed [31:0] value,
                                   logic [3:0] position);
            t_outcome o;
            o.status     = iolst_pkg::STATUS_DONE;
            o.read_value = '0;
            case (func)
                iolst_pkg::FUNC_APPEND: begin
                    if (fill >= DEPTH) begin
                        o.status = iolst_pkg::STATUS_FULL;
                    end else begin
                        cells[fill] = value;
                        fill++;
                    end
                end
                iolst_pkg::FUNC_INSERT: begin
                    if (position == 0 || position >= fill) begin
                        o.status = iolst_pkg::STATUS_RANGE;
                    end else if (fill >= DEPTH) begin
                        o.status = iolst_pkg::STATUS_FULL;
                    end else begin
                        for (int i = fill; i > position; i--) begin
                            cells[i] = cells[i - 1];
                        end
                        cells[position] = value;
                        fill++;
                    end
                end
                iolst_pkg::FUNC_DELETE: begin
                    if (position >= fill) begin
                        o.status = iolst_pkg::STATUS_RANGE;
                    end else begin
                        for (int i = position; i + 1 < fill; i++) begin
                            cells[i] = cells[i + 1];
                        end
                        fill--;
                    end
                end
                default: begin
                    if (position >= fill) begin
                        o.status = iolst_pkg::STATUS_RANGE;
                    end else begin
                        o.read_value = cells[position];
                    end
                end
            endcase
            o.count = fill[4:0];
            outcomes.push_back(o);
        endfunction

        function void check_result(logic [1:0] status, logic signed [31:0] read_value,
                                   logic [4:0] count);
            t_outcome want;
            if (outcomes.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT) begin
                    $display("Unexpected result: status %0d read_value %0d count %0d",
                             status, read_value, count);
                end
                return;
            end
            want = outcomes.pop_front();
            if (status !== want.status || read_value !== want.read_value
                    || count !== want.count) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT) begin
                    $display({"Mismatch: expected status %0d read_value %0d count %0d,",
                              " got status %0d read_value %0d count %0d"},
                             want.status, want.read_value, want.count,
                             status, read_value, count);
                end
            end
        endfunction
    endclass

    logic               i_clk;
    logic               i_rst_n;
    logic               start;
    logic               busy;
    logic [1:0]         i_func;
    logic signed [31:0] i_value;
    logic [3:0]         i_position;
    logic               o_valid;
    logic [1:0]         o_status;
    logic signed [31:0] o_read_value;
    logic [4:0]         o_count;

    list_scoreboard sb;
    bit             no_gap;
    int unsigned    cycles;

    indexed_ordered_list_store #(.DEPTH(DEPTH)) DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_func       (i_func),
        .i_value      (i_value),
        .i_position   (i_position),
        .o_valid      (o_valid),
        .o_status     (o_status),
        .o_read_value (o_read_value),
        .o_count      (o_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && o_valid === 1'b1) begin
            sb.check_result(o_status, o_read_value, o_count);
        end
    end

    // Called at a falling edge; returns at the falling edge after the request is taken.
    task automatic send_request(iolst_pkg::t_func func, logic signed [31:0] value,
                                logic [3:0] position);
        int gap;
        gap = no_gap ? 0 : int'($urandom_range(0, MAX_GAP));
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        start      <= 1'b1;
        i_func     <= func;
        i_value    <= value;
        i_position <= position;
        do @(posedge i_clk); while (busy !== 1'b0);
        sb.note_request(func, value, position);
        @(negedge i_clk);
    endtask

    initial begin
        int                 pick;
        bit                 growing;
        iolst_pkg::t_func   func;
        logic signed [31:0] value;
        logic [3:0]         position;

        sb         = new();
        cycles     = 0;
        no_gap     = 1'b0;
        growing    = 1'b1;
        i_rst_n    = 1'b0;
        start      = 1'b0;
        i_func     = iolst_pkg::FUNC_APPEND;
        i_value    = '0;
        i_position = '0;
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // The empty store, the value extremes, misplaced inserts and deleting the only element.
        send_request(iolst_pkg::FUNC_READ,   32'sd0,            4'd0);
        send_request(iolst_pkg::FUNC_DELETE, 32'sd0,            4'd15);
        send_request(iolst_pkg::FUNC_INSERT, 32'sd7,            4'd0);
        send_request(iolst_pkg::FUNC_INSERT, 32'sd7,            4'd1);
        send_request(iolst_pkg::FUNC_APPEND, 32'sh7FFF_FFFF,    4'd0);
        send_request(iolst_pkg::FUNC_APPEND, 32'sh8000_0000,    4'd15);
        send_request(iolst_pkg::FUNC_APPEND, 32'sd0,            4'd0);
        send_request(iolst_pkg::FUNC_INSERT, 32'sd5,            4'd3);
        send_request(iolst_pkg::FUNC_INSERT, 32'sd5,            4'd0);
        send_request(iolst_pkg::FUNC_INSERT, -32'sd1,           4'd2);
        send_request(iolst_pkg::FUNC_READ,   32'sd0,            4'd2);
        send_request(iolst_pkg::FUNC_READ,   32'sd0,            4'd15);
        send_request(iolst_pkg::FUNC_DELETE, 32'sd0,            4'd3);
        send_request(iolst_pkg::FUNC_DELETE, 32'sd0,            4'd0);
        send_request(iolst_pkg::FUNC_READ,   32'sd0,            4'd0);
        send_request(iolst_pkg::FUNC_DELETE, 32'sd0,            4'd1);
        send_request(iolst_pkg::FUNC_DELETE, 32'sd0,            4'd0);
        send_request(iolst_pkg::FUNC_READ,   32'sd0,            4'd0);
        send_request(iolst_pkg::FUNC_APPEND, 32'shA5A5_A5A5,    4'd15);
        send_request(iolst_pkg::FUNC_READ,   32'sd0,            4'd0);

        // The store fills up to capacity and drains to empty repeatedly.
        for (int n = 0; n < RANDOM_REQUESTS; n++) begin
            if (n % 50 == 0) begin
                no_gap = ($urandom_range(0, 2) == 0);
            end
            if (growing && sb.fill == DEPTH && $urandom_range(0, 3) == 0) begin
                growing = 1'b0;
            end else if (!growing && sb.fill == 0 && $urandom_range(0, 3) == 0) begin
                growing = 1'b1;
            end
            pick = int'($urandom_range(0, 99));
            if (growing) begin
                func = (pick < 45) ? iolst_pkg::FUNC_APPEND :
                       (pick < 80) ? iolst_pkg::FUNC_INSERT :
                       (pick < 90) ? iolst_pkg::FUNC_READ : iolst_pkg::FUNC_DELETE;
            end else begin
                func = (pick < 50) ? iolst_pkg::FUNC_DELETE :
                       (pick < 80) ? iolst_pkg::FUNC_READ :
                       (pick < 90) ? iolst_pkg::FUNC_APPEND : iolst_pkg::FUNC_INSERT;
            end
            if ($urandom_range(0, 4) == 0) begin
                position = 4'($urandom_range(0, 15));
            end else if (func == iolst_pkg::FUNC_INSERT && sb.fill >= 2) begin
                position = 4'($urandom_range(1, sb.fill - 1));
            end else if (func != iolst_pkg::FUNC_INSERT && sb.fill >= 1) begin
                position = 4'($urandom_range(0, sb.fill - 1));
            end else begin
                position = 4'($urandom_range(0, 15));
            end
            pick = int'($urandom_range(0, 9));
            if (pick == 0) begin
                value = 32'sh7FFF_FFFF;
            end else if (pick == 1) begin
                value = 32'sh8000_0000;
            end else begin
                value = $urandom;
            end
            send_request(func, value, position);
        end

        start <= 1'b0;
        while (sb.outcomes.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        if (sb.mismatches == 0 && sb.outcomes.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
